[hdl/dmat_pkg.sv]
// Shared types and constants for the dual motion alarm timer.
// No dependencies; compiled first.
`default_nettype none

package dmat_pkg;

  localparam int unsigned NOW_W      = 32;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_SENTINEL_MODE     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PERSIST_MS        = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BOTH_BUZZ_MS      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SINGLE_BUZZ_MS    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALERT_INTERVAL_MS = 3'd4;

  // Configuration reset values
  localparam logic              RST_SENTINEL_MODE     = 1'b1;
  localparam logic [HOLD_W-1:0] RST_PERSIST_MS        = 16'd10000;
  localparam logic [HOLD_W-1:0] RST_BOTH_BUZZ_MS      = 16'd30000;
  localparam logic [HOLD_W-1:0] RST_SINGLE_BUZZ_MS    = 16'd10000;
  localparam logic [HOLD_W-1:0] RST_ALERT_INTERVAL_MS = 16'd20000;

  // Alert kind codes
  localparam logic [1:0] ALERT_NONE  = 2'd0;
  localparam logic [1:0] ALERT_BOTH  = 2'd1;
  localparam logic [1:0] ALERT_PIR   = 2'd2;
  localparam logic [1:0] ALERT_RADAR = 2'd3;

  typedef struct packed {
    logic [NOW_W-1:0] now_ms;
    logic             sample_strobe;
    logic             pir_level;
    logic             radar_level;
    logic             link_ready;
  } in_item_t;

  typedef struct packed {
    logic       buzzer_on;
    logic       pir_active;
    logic       radar_active;
    logic [1:0] alert_kind;
  } result_t;

  typedef struct packed {
    logic              sentinel_mode;
    logic [HOLD_W-1:0] persist_ms;
    logic [HOLD_W-1:0] both_buzz_ms;
    logic [HOLD_W-1:0] single_buzz_ms;
    logic [HOLD_W-1:0] alert_interval_ms;
  } cfg_t;

endpackage

`default_nettype wire

[hdl/dmat_chan_if.sv]
// Valid/ready channel carrying one payload per transfer.
// Payload type is supplied by the instantiating scope (see dmat_pkg).
`default_nettype none

interface dmat_chan_if #(
  parameter type payload_t = logic [0:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/dmat_cfg.sv]
// Configuration register file for the alarm timer.
// Depends on dmat_pkg.
`default_nettype none

module dmat_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [dmat_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [dmat_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output dmat_pkg::cfg_t                        cfg
);
  import dmat_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_SENTINEL_MODE:     cfg_nxt.sentinel_mode     = cfg_wdata[0];
        CFG_PERSIST_MS:        cfg_nxt.persist_ms        = cfg_wdata[HOLD_W-1:0];
        CFG_BOTH_BUZZ_MS:      cfg_nxt.both_buzz_ms      = cfg_wdata[HOLD_W-1:0];
        CFG_SINGLE_BUZZ_MS:    cfg_nxt.single_buzz_ms    = cfg_wdata[HOLD_W-1:0];
        CFG_ALERT_INTERVAL_MS: cfg_nxt.alert_interval_ms = cfg_wdata[HOLD_W-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sentinel_mode     <= RST_SENTINEL_MODE;
      cfg_r.persist_ms        <= RST_PERSIST_MS;
      cfg_r.both_buzz_ms      <= RST_BOTH_BUZZ_MS;
      cfg_r.single_buzz_ms    <= RST_SINGLE_BUZZ_MS;
      cfg_r.alert_interval_ms <= RST_ALERT_INTERVAL_MS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[hdl/dmat_core.sv]
// Detection stretch, buzzer hold and rate-limited alert logic with its
// deadline registers. Depends on dmat_pkg.
`default_nettype none

module dmat_core #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  wire dmat_pkg::in_item_t item,
  input  wire dmat_pkg::cfg_t     cfg,
  output dmat_pkg::result_t  res
);
  import dmat_pkg::*;

  typedef logic [TIME_WIDTH-1:0] tstamp_t;

  tstamp_t pir_hold_r,   pir_hold_nxt;
  tstamp_t radar_hold_r, radar_hold_nxt;
  tstamp_t buzz_hold_r,  buzz_hold_nxt;
  tstamp_t last_both_r,  last_both_nxt;
  tstamp_t last_pir_r,   last_pir_nxt;
  tstamp_t last_radar_r, last_radar_nxt;

  tstamp_t now_t;
  tstamp_t persist_t, both_t, single_t, interval_t;
  logic    pir_act, radar_act;
  logic    both_gap_ok, pir_gap_ok, radar_gap_ok;
  logic    alert_en;
  logic [1:0] kind;

  // now is truncated or zero-extended into the time width
  assign now_t      = TIME_WIDTH'(item.now_ms);
  assign persist_t  = TIME_WIDTH'(cfg.persist_ms);
  assign both_t     = TIME_WIDTH'(cfg.both_buzz_ms);
  assign single_t   = TIME_WIDTH'(cfg.single_buzz_ms);
  assign interval_t = TIME_WIDTH'(cfg.alert_interval_ms);

  // wrapping differences against the last alert times
  assign both_gap_ok  = tstamp_t'(now_t - last_both_r)  > interval_t;
  assign pir_gap_ok   = tstamp_t'(now_t - last_pir_r)   > interval_t;
  assign radar_gap_ok = tstamp_t'(now_t - last_radar_r) > interval_t;

  assign alert_en = cfg.sentinel_mode & item.link_ready;

  always_comb begin
    pir_hold_nxt   = pir_hold_r;
    radar_hold_nxt = radar_hold_r;
    if (item.sample_strobe && item.pir_level) begin
      pir_hold_nxt = now_t + persist_t;
    end
    if (item.sample_strobe && item.radar_level) begin
      radar_hold_nxt = now_t + persist_t;
    end

    pir_act   = now_t < pir_hold_nxt;
    radar_act = now_t < radar_hold_nxt;

    buzz_hold_nxt = buzz_hold_r;
    if (pir_act && radar_act) begin
      buzz_hold_nxt = now_t + both_t;
    end else if ((pir_act || radar_act) && (buzz_hold_r < now_t)) begin
      buzz_hold_nxt = now_t + single_t;
    end

    kind           = ALERT_NONE;
    last_both_nxt  = last_both_r;
    last_pir_nxt   = last_pir_r;
    last_radar_nxt = last_radar_r;
    if (alert_en) begin
      if (pir_act && radar_act && both_gap_ok) begin
        kind          = ALERT_BOTH;
        last_both_nxt = now_t;
      end else if (pir_act && pir_gap_ok) begin
        kind         = ALERT_PIR;
        last_pir_nxt = now_t;
      end else if (radar_act && radar_gap_ok) begin
        kind           = ALERT_RADAR;
        last_radar_nxt = now_t;
      end
    end

    res.buzzer_on    = now_t < buzz_hold_nxt;
    res.pir_active   = pir_act;
    res.radar_active = radar_act;
    res.alert_kind   = kind;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pir_hold_r   <= '0;
      radar_hold_r <= '0;
      buzz_hold_r  <= '0;
      last_both_r  <= '0;
      last_pir_r   <= '0;
      last_radar_r <= '0;
    end else if (adv) begin
      pir_hold_r   <= pir_hold_nxt;
      radar_hold_r <= radar_hold_nxt;
      buzz_hold_r  <= buzz_hold_nxt;
      last_both_r  <= last_both_nxt;
      last_pir_r   <= last_pir_nxt;
      last_radar_r <= last_radar_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/dual_motion_alarm_timer.sv]
// Top level of the dual-sensor motion alarm timer.
// Depends on dmat_pkg, dmat_chan_if, dmat_cfg and dmat_core.
//
//   channel    dir   payload                                            handshake
//   in_chan    in    now_ms, sample_strobe, pir_level, radar_level,     valid/ready
//                    link_ready
//   out_chan   out   buzzer_on, pir_active, radar_active, alert_kind    valid/ready
//   cfg_*      in    cfg_addr selects register, cfg_wdata               cfg_we only
//
// One transfer per cycle sustained while out_chan is not stalled; an input item
// is held first in the input register and then in the result register, from
// which it is offered on out_chan.
// The deadline compares and adds sit in one stage between the two registers;
// the deadline registers update in the cycle an item moves into the result
// register, so the next item already sees them.
// A stalled output holds the result register and the input register; the
// input side stays ready while either register can still take an item.
// rst_n is synchronous: clears valids and deadlines, loads config defaults.
`default_nettype none

module dual_motion_alarm_timer #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  dmat_chan_if.sink                             in_chan,
  dmat_chan_if.source                           out_chan,
  input  wire logic                             cfg_we,
  input  wire logic [dmat_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [dmat_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dmat_pkg::*;

  cfg_t     cfg;
  in_item_t s1_item_r;
  logic     s1_valid_r, s1_valid_nxt;
  result_t  out_res_r;
  result_t  core_res;
  logic     out_valid_r, out_valid_nxt;
  logic     out_free;
  logic     s1_go;
  logic     in_xfer;

  dmat_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dmat_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (s1_go),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (core_res)
  );

  // result register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_chan.ready;
  assign s1_go    = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || out_free;
  assign in_xfer  = in_chan.valid && in_chan.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_chan.data;
    end
    if (s1_go) begin
      out_res_r <= core_res;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_res_r;

endmodule

`default_nettype wire
